// ===== rtl/qsm_pkg.sv =====
// Shared types, constants and decode table for the quadrature speed meter.
`timescale 1ns / 1ps
`default_nettype none

package qsm_pkg;

  localparam int PULSE_BITS    = 24;
  localparam int MS_PER_MINUTE = 60000;
  localparam int SPEED_W       = 24;
  localparam int FRAC_BITS     = 8;
  localparam int SCALE_W       = 24;
  localparam int CPR_W         = 16;
  localparam int WIN_W         = 16;
  localparam int TIME_W        = 32;
  localparam int NUM_W         = PULSE_BITS + SCALE_W;
  localparam int DEN_W         = CPR_W + TIME_W;
  localparam int CNT_W         = $clog2(SPEED_W);
  localparam int ADDR_W        = 3;
  localparam int DATA_W        = 32;

  localparam logic [SCALE_W-1:0] SPEED_SCALE = SCALE_W'(MS_PER_MINUTE * (1 << FRAC_BITS));
  localparam logic [SPEED_W-1:0] SPEED_MAX   = {SPEED_W{1'b1}};
  localparam logic [CNT_W-1:0]   DIV_LAST    = CNT_W'(SPEED_W - 1);

  localparam logic [CPR_W-1:0] CPR_RESET = CPR_W'(1600);
  localparam logic [WIN_W-1:0] WIN_RESET = WIN_W'(125);

  // register indexes, selected by paddr[2]
  localparam logic REG_COUNTS_PER_REV = 1'b0;
  localparam logic REG_WINDOW_MS      = 1'b1;

  localparam logic [1:0] DIR_NONE = 2'b00;
  localparam logic [1:0] DIR_CW   = 2'b01;
  localparam logic [1:0] DIR_CCW  = 2'b11;

  typedef struct packed {
    logic              level_a;
    logic              level_b;
    logic              sample_strobe;
    logic [TIME_W-1:0] now_ms;
  } enc_t;

  typedef struct packed {
    logic signed [1:0]  turn_dir;
    logic [SPEED_W-1:0] speed_rpm;
    logic               speed_updated;
  } speed_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_TIME,
    ST_MUL,
    ST_CHECK,
    ST_DIV,
    ST_FINISH
  } state_t;

  typedef struct packed {
    logic accept;
    logic time_cap;
    logic mul;
    logic check;
    logic div_step;
    logic out_load;
  } dp_cmd_t;

  typedef struct packed {
    logic due;
    logic special;
    logic div_last;
    logic out_busy;
  } dp_stat_t;

  // x4 transition table: {prev_ab, ab} -> direction code, DIR_NONE for a double jump
  function automatic logic [1:0] classify(input logic [3:0] code);
    logic [1:0] dir;
    case (code)
      4'b0001, 4'b0111, 4'b1110, 4'b1000: dir = DIR_CW;
      4'b0010, 4'b0100, 4'b1101, 4'b1011: dir = DIR_CCW;
      default:                            dir = DIR_NONE;
    endcase
    return dir;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/qsm_ctrl.sv =====
// Controller state machine sequencing decode, window check and speed divide.
`timescale 1ns / 1ps
`default_nettype none

module qsm_ctrl (
  input  wire               clk,
  input  wire               rst,
  input  wire               enc_valid,
  output logic              idle,
  input  qsm_pkg::dp_stat_t stat,
  output qsm_pkg::dp_cmd_t  cmd
);
  import qsm_pkg::*;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    idle       = 1'b0;
    case (state)
      ST_IDLE: begin
        idle = 1'b1;
        if (enc_valid) begin
          cmd.accept = 1'b1;
          state_next = ST_TIME;
        end
      end
      ST_TIME: begin
        cmd.time_cap = 1'b1;
        state_next   = stat.due ? ST_MUL : ST_FINISH;
      end
      ST_MUL: begin
        cmd.mul    = 1'b1;
        state_next = ST_CHECK;
      end
      ST_CHECK: begin
        cmd.check  = 1'b1;
        state_next = stat.special ? ST_FINISH : ST_DIV;
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        if (stat.div_last) begin
          state_next = ST_FINISH;
        end
      end
      ST_FINISH: begin
        // hold until the result register is free
        if (!stat.out_busy) begin
          cmd.out_load = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

// ===== rtl/qsm_dp.sv =====
// Datapath: decode state, pulse count, window timing, iterative divider, result register.
`timescale 1ns / 1ps
`default_nettype none

module qsm_dp (
  input  wire                                clk,
  input  wire                                rst,
  input  qsm_pkg::enc_t                      enc,
  input  wire [qsm_pkg::CPR_W-1:0]           counts_per_rev,
  input  wire [qsm_pkg::WIN_W-1:0]           window_ms,
  input  qsm_pkg::dp_cmd_t                   cmd,
  output qsm_pkg::dp_stat_t                  stat,
  output logic                               speed_valid,
  input  wire                                speed_stall,
  output qsm_pkg::speed_t                    speed
);
  import qsm_pkg::*;

  logic [1:0]            prev_ab;
  logic [1:0]            dir_reg;
  logic [PULSE_BITS-1:0] pulses;
  logic [TIME_W-1:0]     window_start;
  logic [SPEED_W-1:0]    speed_reg;
  logic [TIME_W-1:0]     now_reg;
  logic [TIME_W-1:0]     delta;
  logic                  upd;
  logic [NUM_W-1:0]      num;
  logic [DEN_W-1:0]      den;
  logic [DEN_W-1:0]      rem;
  logic [SPEED_W-1:0]    quo;
  logic [SPEED_W-1:0]    nlow;
  logic [CNT_W-1:0]      cnt;

  logic [1:0]            ab;
  logic [1:0]            dir_code;
  logic [TIME_W-1:0]     diff;
  logic                  due;
  logic [DEN_W-1:0]      num_hi;
  logic                  den_zero;
  logic                  sat;
  logic [DEN_W:0]        rem_shift;
  logic                  q_bit;
  logic [DEN_W:0]        rem_diff;

  assign ab       = {enc.level_a, enc.level_b};
  assign dir_code = classify({prev_ab, ab});
  assign diff     = now_reg - window_start;
  assign due      = diff >= TIME_W'(window_ms);

  assign num_hi   = DEN_W'(num[NUM_W-1:SPEED_W]);
  assign den_zero = (den == '0);
  assign sat      = num_hi >= den;

  // one restoring step: bring in the next numerator bit
  assign rem_shift = {rem, nlow[SPEED_W-1]};
  assign q_bit     = rem_shift >= {1'b0, den};
  assign rem_diff  = rem_shift - {1'b0, den};

  assign stat.due      = due;
  assign stat.special  = den_zero || sat;
  assign stat.div_last = (cnt == DIV_LAST);
  assign stat.out_busy = speed_valid && speed_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      prev_ab      <= 2'b00;
      dir_reg      <= DIR_NONE;
      pulses       <= '0;
      window_start <= '0;
      speed_reg    <= '0;
      speed_valid  <= 1'b0;
    end else begin
      if (cmd.accept) begin
        now_reg <= enc.now_ms;
        if (enc.sample_strobe && (ab != prev_ab)) begin
          prev_ab <= ab;
          if (dir_code != DIR_NONE) begin
            dir_reg <= dir_code;
            if (pulses != {PULSE_BITS{1'b1}}) begin
              pulses <= pulses + 1'b1;
            end
          end
        end
      end

      if (cmd.time_cap) begin
        delta <= diff;
        upd   <= due;
        if (due) begin
          window_start <= now_reg;
        end
      end

      if (cmd.mul) begin
        num    <= NUM_W'(pulses) * NUM_W'(SPEED_SCALE);
        den    <= DEN_W'(counts_per_rev) * DEN_W'(delta);
        pulses <= '0;
      end

      if (cmd.check) begin
        rem  <= num_hi;
        nlow <= num[SPEED_W-1:0];
        quo  <= '0;
        cnt  <= '0;
        if (den_zero) begin
          speed_reg <= (num == '0) ? '0 : SPEED_MAX;
        end else if (sat) begin
          speed_reg <= SPEED_MAX;
        end
      end

      if (cmd.div_step) begin
        rem  <= q_bit ? rem_diff[DEN_W-1:0] : rem_shift[DEN_W-1:0];
        nlow <= {nlow[SPEED_W-2:0], 1'b0};
        quo  <= {quo[SPEED_W-2:0], q_bit};
        cnt  <= cnt + 1'b1;
        if (cnt == DIV_LAST) begin
          speed_reg <= {quo[SPEED_W-2:0], q_bit};
        end
      end

      if (cmd.out_load) begin
        speed_valid         <= 1'b1;
        speed.turn_dir      <= dir_reg;
        speed.speed_rpm     <= speed_reg;
        speed.speed_updated <= upd;
      end else if (speed_valid && !speed_stall) begin
        speed_valid <= 1'b0;
      end
    end
  end

endmodule

`default_nettype wire

// ===== rtl/quadrature_speed_meter.sv =====
// Top level: configuration registers, controller and datapath of the speed meter.
// Sequence: accept, window time capture, then the result without a speed update; an update
// adds multiply, check and 24 divide steps, the divide skipped on a zero divisor or saturation.
// Flow: no new sample is accepted until the previous one is finished, and a finished result
// waits while the previous one has not left a stalled output.
// Reset: synchronous; clears decode state, count, window and speed, config to 1600 and 125.
`timescale 1ns / 1ps
`default_nettype none

module quadrature_speed_meter (
  input  wire                          clk,
  input  wire                          rst,
  input  wire                          enc_valid,
  output logic                         enc_stall,
  input  qsm_pkg::enc_t                enc,
  output logic                         speed_valid,
  input  wire                          speed_stall,
  output qsm_pkg::speed_t              speed,
  input  wire                          psel,
  input  wire                          penable,
  input  wire                          pwrite,
  input  wire [qsm_pkg::ADDR_W-1:0]    paddr,
  input  wire [qsm_pkg::DATA_W-1:0]    pwdata,
  output logic [qsm_pkg::DATA_W-1:0]   prdata,
  output logic                         pready
);
  import qsm_pkg::*;

  logic [CPR_W-1:0] counts_per_rev;
  logic [WIN_W-1:0] window_ms;
  logic             idle;
  dp_cmd_t          cmd;
  dp_stat_t         stat;

  assign pready    = 1'b1;
  assign enc_stall = !idle;

  always_ff @(posedge clk) begin
    if (rst) begin
      counts_per_rev <= CPR_RESET;
      window_ms      <= WIN_RESET;
    end else if (psel && penable && pwrite) begin
      case (paddr[2])
        REG_COUNTS_PER_REV: counts_per_rev <= pwdata[CPR_W-1:0];
        REG_WINDOW_MS:      window_ms      <= pwdata[WIN_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      REG_COUNTS_PER_REV: prdata = DATA_W'(counts_per_rev);
      REG_WINDOW_MS:      prdata = DATA_W'(window_ms);
      default:            prdata = '0;
    endcase
  end

  qsm_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .enc_valid (enc_valid),
    .idle      (idle),
    .stat      (stat),
    .cmd       (cmd)
  );

  qsm_dp u_dp (
    .clk            (clk),
    .rst            (rst),
    .enc            (enc),
    .counts_per_rev (counts_per_rev),
    .window_ms      (window_ms),
    .cmd            (cmd),
    .stat           (stat),
    .speed_valid    (speed_valid),
    .speed_stall    (speed_stall),
    .speed          (speed)
  );

endmodule

`default_nettype wire
